/* rtl/core/image_scale_by_two_macros.svh */
// Assertion macros used by the scaler RTL.
`ifndef IMAGE_SCALE_BY_TWO_MACROS_SVH
`define IMAGE_SCALE_BY_TWO_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ISB_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, also while reset is held.
`define ISB_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/isb_pkg.sv */
// Types and constants of the scale-by-two image block.
package isb_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	// Column and row counters.
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	// Line store of horizontal pair sums.
	localparam int PAIR_DEPTH = MAX_WIDTH / 2;
	localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
	localparam int SUM_W      = 9;
	localparam int PAIR_W     = 3 * SUM_W;

	// Widths fixed by the interface.
	localparam int PIX_W   = 8;
	localparam int COORD_W = 12;
	localparam int DIM_W   = 12;
	localparam int IDX_W   = 2;

	// Wide enough for a register value, a clamped dimension and a counter plus one.
	localparam int CMP_W = ((COL_W > ROW_W ? COL_W : ROW_W) + 1 > DIM_W + 1) ?
		(COL_W > ROW_W ? COL_W : ROW_W) + 1 : DIM_W + 1;

	typedef enum logic [1:0] {
		MODE_PASS   = 2'd0,
		MODE_HALVE  = 2'd1,
		MODE_DOUBLE = 2'd2
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_MODE   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	localparam logic [1:0] LAST_BEAT = 2'd3;

	// A zero dimension counts as one, an oversized one saturates.
	function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [CMP_W-1:0] maxv);
		logic [CMP_W-1:0] ext;
		ext = CMP_W'(v);
		if (ext == '0) begin
			return CMP_W'(1);
		end
		return (ext > maxv) ? maxv : ext;
	endfunction

endpackage

/* rtl/core/image_scale_by_two.sv */
// Scale-by-two image block: pass, 2x2 box halving and 2x pixel replication.
//
//  channel   direction  payload (lowest bits first)                     handshake
//  s_*       in         tdata: red, green, blue                         tvalid/tready
//  m_*       out        tdata: out_red, out_green, out_blue, out_col,   tvalid/tready
//                              out_row; tlast: frame_done
//  cfg_*     in         cfg_index: register, cfg_data: value            cfg_valid/cfg_ready
//
// A pixel enters on its handshake; in doubling mode the output register sends four words
// for it, so the result port limits the rate. Pass and halving modes take one pixel
// per cycle when not stalled by m_tready, through stage 1 and the stage 2 register.
// Halving reads and writes the pair-sum line store in the accept cycle; its read data
// is registered and added in the next stage. The line store is not cleared by reset.
// Reset clears counters and valid bits and loads pass mode, 640x480; cfg_ready stays high.
`include "image_scale_by_two_macros.svh"

module image_scale_by_two (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [23:0]                 s_tdata,    // red, green, blue
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [47:0]                 m_tdata,    // out_red, out_green, out_blue, out_col, out_row
	output logic                        m_tlast,    // frame_done
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [isb_pkg::IDX_W-1:0]   cfg_index,
	input  logic [isb_pkg::DIM_W-1:0]   cfg_data
);
	import isb_pkg::*;

	// Configuration and frame position.
	logic [1:0]       mode_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [PIX_W-1:0] held_r_q, held_g_q, held_b_q;

	// Line store.
	logic [PAIR_W-1:0]  pair_mem [PAIR_DEPTH];
	logic [PAIR_W-1:0]  rd_q;
	logic [PAIR_AW-1:0] mem_addr;
	logic               mem_we;
	logic               mem_re;
	logic [PAIR_W-1:0]  mem_wdata;

	// Stage 1: pixel accepted, line store accessed.
	logic               valid_s1;
	logic               emit_s1;
	logic               addmem_s1;
	logic               dbl_s1;
	logic               done_s1;
	logic [SUM_W-1:0]   sum_r_s1, sum_g_s1, sum_b_s1;
	logic [COORD_W-1:0] col_s1, row_s1;

	// Stage 2: output register.
	logic               valid_s2;
	logic               dbl_s2;
	logic               done_s2;
	logic [1:0]         beat_s2;
	logic [PIX_W-1:0]   red_s2, green_s2, blue_s2;
	logic [COORD_W-1:0] col_s2, row_s2;

	mode_t            mode;
	logic             cfg_wr;
	logic             s_acc;
	logic             fin_s2;
	logic             adv_s1;
	logic             load_s2;
	logic [CMP_W-1:0] w_eff, h_eff;
	logic [CMP_W-1:0] col_next, row_next;
	logic             col_end, row_end, last_pix;
	logic             odd_col, odd_row;
	logic             halve_done;
	logic [SUM_W-1:0] sr, sg, sb;
	logic [SUM_W+1:0] tot_r, tot_g, tot_b;

	always_comb begin
		case (mode_q)
			MODE_HALVE:  mode = MODE_HALVE;
			MODE_DOUBLE: mode = MODE_DOUBLE;
			default:     mode = MODE_PASS;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && (cfg_index == REG_MODE || cfg_index == REG_WIDTH ||
		cfg_index == REG_HEIGHT);

	assign w_eff    = clamp_dim(width_q, CMP_W'(MAX_WIDTH));
	assign h_eff    = clamp_dim(height_q, CMP_W'(MAX_HEIGHT));
	assign col_next = CMP_W'(col_q) + CMP_W'(1);
	assign row_next = CMP_W'(row_q) + CMP_W'(1);
	assign col_end  = col_next >= w_eff;
	assign row_end  = row_next >= h_eff;
	assign last_pix = col_end && row_end;
	assign odd_col  = col_q[0];
	assign odd_row  = row_q[0];
	assign halve_done = (CMP_W'(col_q >> 1) + CMP_W'(1) == (w_eff >> 1)) &&
		(CMP_W'(row_q >> 1) + CMP_W'(1) == (h_eff >> 1));

	assign sr = SUM_W'(held_r_q) + SUM_W'(s_tdata[7:0]);
	assign sg = SUM_W'(held_g_q) + SUM_W'(s_tdata[15:8]);
	assign sb = SUM_W'(held_b_q) + SUM_W'(s_tdata[23:16]);

	// The output register frees up on the last word of its item.
	assign fin_s2  = valid_s2 && m_tready && (!dbl_s2 || beat_s2 == LAST_BEAT);
	assign adv_s1  = valid_s1 && (!emit_s1 || !valid_s2 || fin_s2);
	assign load_s2 = valid_s1 && emit_s1 && (!valid_s2 || fin_s2);
	assign s_tready = !valid_s1 || adv_s1;
	assign s_acc    = s_tvalid && s_tready;

	assign mem_addr  = PAIR_AW'(col_q >> 1);
	assign mem_we    = s_acc && mode == MODE_HALVE && odd_col && !odd_row;
	assign mem_re    = s_acc && mode == MODE_HALVE && odd_col && odd_row;
	assign mem_wdata = {sb, sg, sr};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pair_mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= pair_mem[mem_addr];
		end
	end

	// Configuration writes restart the frame and win over an accepted pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PASS;
			width_q  <= DIM_W'(640);
			height_q <= DIM_W'(480);
			col_q    <= '0;
			row_q    <= '0;
			held_r_q <= '0;
			held_g_q <= '0;
			held_b_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[1:0];
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    mode_q   <= mode_q;
			endcase
			col_q    <= '0;
			row_q    <= '0;
			held_r_q <= '0;
			held_g_q <= '0;
			held_b_q <= '0;
		end else if (s_acc) begin
			if (mode == MODE_HALVE && !odd_col) begin
				held_r_q <= s_tdata[7:0];
				held_g_q <= s_tdata[15:8];
				held_b_q <= s_tdata[23:16];
			end
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : ROW_W'(row_next);
			end else begin
				col_q <= COL_W'(col_next);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			dbl_s1 <= mode == MODE_DOUBLE;
			case (mode)
				MODE_HALVE: begin
					emit_s1   <= odd_col && odd_row;
					addmem_s1 <= 1'b1;
					done_s1   <= halve_done;
					sum_r_s1  <= sr;
					sum_g_s1  <= sg;
					sum_b_s1  <= sb;
					col_s1    <= COORD_W'(col_q >> 1);
					row_s1    <= COORD_W'(row_q >> 1);
				end
				MODE_DOUBLE: begin
					emit_s1   <= 1'b1;
					addmem_s1 <= 1'b0;
					done_s1   <= last_pix;
					sum_r_s1  <= SUM_W'(s_tdata[7:0]);
					sum_g_s1  <= SUM_W'(s_tdata[15:8]);
					sum_b_s1  <= SUM_W'(s_tdata[23:16]);
					col_s1    <= COORD_W'({col_q, 1'b0});
					row_s1    <= COORD_W'({row_q, 1'b0});
				end
				default: begin
					emit_s1   <= 1'b1;
					addmem_s1 <= 1'b0;
					done_s1   <= last_pix;
					sum_r_s1  <= SUM_W'(s_tdata[7:0]);
					sum_g_s1  <= SUM_W'(s_tdata[15:8]);
					sum_b_s1  <= SUM_W'(s_tdata[23:16]);
					col_s1    <= COORD_W'(col_q);
					row_s1    <= COORD_W'(row_q);
				end
			endcase
		end
	end

	// Block total of the 2x2 average: this row's pair plus the stored pair above.
	assign tot_r = (SUM_W+2)'(sum_r_s1) + (SUM_W+2)'(rd_q[SUM_W-1:0]);
	assign tot_g = (SUM_W+2)'(sum_g_s1) + (SUM_W+2)'(rd_q[2*SUM_W-1:SUM_W]);
	assign tot_b = (SUM_W+2)'(sum_b_s1) + (SUM_W+2)'(rd_q[3*SUM_W-1:2*SUM_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			beat_s2  <= '0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
			beat_s2  <= '0;
		end else if (fin_s2) begin
			valid_s2 <= 1'b0;
			beat_s2  <= '0;
		end else if (valid_s2 && m_tready && dbl_s2) begin
			beat_s2 <= beat_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			dbl_s2  <= dbl_s1;
			done_s2 <= done_s1;
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			if (addmem_s1) begin
				red_s2   <= PIX_W'(tot_r >> 2);
				green_s2 <= PIX_W'(tot_g >> 2);
				blue_s2  <= PIX_W'(tot_b >> 2);
			end else begin
				red_s2   <= sum_r_s1[PIX_W-1:0];
				green_s2 <= sum_g_s1[PIX_W-1:0];
				blue_s2  <= sum_b_s1[PIX_W-1:0];
			end
		end
	end

	// Doubling walks the 2x2 block with the row offset changing fastest.
	assign m_tvalid = valid_s2;
	assign m_tlast  = done_s2 && (!dbl_s2 || beat_s2 == LAST_BEAT);
	assign m_tdata  = {
		dbl_s2 ? {row_s2[COORD_W-1:1], beat_s2[0]} : row_s2,
		dbl_s2 ? {col_s2[COORD_W-1:1], beat_s2[1]} : col_s2,
		blue_s2, green_s2, red_s2
	};

	`ISB_ASSERT(a_ready_when_empty, !valid_s1 |-> s_tready, "input stalled with stage 1 empty")
	`ISB_ASSERT(a_beat_only_double, valid_s2 && !dbl_s2 |-> beat_s2 == '0, "beat count outside doubling")
	`ISB_ASSERT(a_last_on_final_beat, m_tvalid && m_tlast && dbl_s2 |-> beat_s2 == LAST_BEAT, "frame end before the last replicated word")
	`ISB_ASSERT(a_cfg_restarts, cfg_wr |=> col_q == '0 && row_q == '0, "register write did not restart the frame")
	`ISB_ASSERT_ALWAYS(a_no_mem_rw_overlap, !(mem_we && mem_re), "line store read and written by one pixel")

endmodule
